[rtl/lkvc_pkg.sv]
// Shared constants and types of the LRU key-value cache.
`default_nettype none

package lkvc_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 64;
    localparam int VALUE_BITS = 64;
    localparam int RANK_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W      = $clog2(ENTRIES + 1);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Partial results rippling along the row of entries during the compare.
    typedef struct packed {
        logic                  claimed;
        logic                  hit;
        logic [RANK_W-1:0]     rank;
        logic [VALUE_BITS-1:0] value;
    } chain_t;

    // Update command broadcast to every entry.
    typedef struct packed {
        logic                  en;
        logic                  op;
        logic                  hit;
        logic [RANK_W-1:0]     hit_rank;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } upd_t;

endpackage

`default_nettype wire

[rtl/lru_key_value_cache.sv]
// Fully associative key-value cache with LRU replacement, built as a row of entry cells.
// A request transfer is registered, compared along the cell row in the compare state,
// then applied in the update state once the output register is free, loading the result.
// A new request is taken while idle, or while the previous request's update is applied.
// Reset (rst_n low, asynchronous) empties the cache and clears all handshake state.
`default_nettype none

module lru_key_value_cache (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [127:0]                         s_tdata,  // key[63:0], value[127:64]
    input  wire logic [0:0]                           s_tuser,  // op[0]
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [lkvc_pkg::VALUE_BITS-1:0]           m_tdata,  // read_value[63:0]
    output logic [0:0]                                m_tuser   // hit[0]
);
    import lkvc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CMP  = 3'b010,
        ST_UPD  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic                  op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;

    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  res_hit_reg;
    logic [RANK_W-1:0]     res_rank_reg;
    logic [VALUE_BITS-1:0] res_value_reg;

    logic                  out_valid_reg, out_valid_next;
    logic                  out_hit_reg;
    logic [VALUE_BITS-1:0] out_value_reg;

    logic   accept;
    logic   upd_fire;
    logic   full;
    upd_t   upd;
    chain_t chain [0:ENTRIES];

    assign upd_fire = (state_reg == ST_UPD) && (!out_valid_reg || m_tready);
    assign s_tready = (state_reg == ST_IDLE) || upd_fire;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(ENTRIES));

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_value_reg;
    assign m_tuser[0] = out_hit_reg;

    always_comb
    begin
        upd.en       = upd_fire;
        upd.op       = op_reg;
        upd.hit      = res_hit_reg;
        upd.hit_rank = res_rank_reg;
        upd.key      = key_reg;
        upd.value    = value_reg;
    end

    assign chain[0] = '0;

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        lkvc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .full      (full),
            .cmp_en    (state_reg == ST_CMP),
            .cmp_key   (key_reg),
            .upd       (upd),
            .chain_in  (chain[g]),
            .chain_out (chain[g+1])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_CMP;
            ST_CMP:  state_next = ST_UPD;
            ST_UPD:
            begin
                if (upd_fire)
                begin
                    state_next = accept ? ST_CMP : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (upd_fire && (op_reg == OP_INSERT) && !res_hit_reg && !full)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (upd_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= s_tuser[0];
            key_reg   <= s_tdata[KEY_BITS-1:0];
            value_reg <= s_tdata[64 +: VALUE_BITS];
        end
        if (state_reg == ST_CMP)
        begin
            res_hit_reg   <= chain[ENTRIES].hit;
            res_rank_reg  <= chain[ENTRIES].rank;
            res_value_reg <= chain[ENTRIES].value;
        end
        if (upd_fire)
        begin
            out_hit_reg   <= res_hit_reg;
            out_value_reg <= (op_reg == OP_LOOKUP) ? res_value_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

[rtl/lkvc_cell.sv]
// One cache entry: key, value, valid bit and recency rank, with its compare logic.
`default_nettype none

module lkvc_cell (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           full,
    input  wire logic                           cmp_en,
    input  wire logic [lkvc_pkg::KEY_BITS-1:0]  cmp_key,
    input  wire lkvc_pkg::upd_t                 upd,
    input  wire lkvc_pkg::chain_t               chain_in,
    output lkvc_pkg::chain_t                    chain_out
);
    import lkvc_pkg::*;

    logic [KEY_BITS-1:0]   key_reg,   key_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic                  valid_reg, valid_next;
    logic [RANK_W-1:0]     rank_reg,  rank_next;
    logic                  match_reg, match_next;
    logic                  claim_reg, claim_next;

    logic match;
    logic candidate;

    assign match = valid_reg && (key_reg == cmp_key);

    // When full, the victim is the least recent entry; otherwise the first free slot.
    assign candidate = full ? (valid_reg && (rank_reg == RANK_W'(ENTRIES - 1))) : !valid_reg;

    always_comb
    begin
        chain_out.claimed = chain_in.claimed | candidate;
        chain_out.hit     = chain_in.hit | match;
        chain_out.rank    = chain_in.rank | (match ? rank_reg : '0);
        chain_out.value   = chain_in.value | (match ? value_reg : '0);
    end

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        valid_next = valid_reg;
        rank_next  = rank_reg;
        match_next = match_reg;
        claim_next = claim_reg;
        if (cmp_en)
        begin
            match_next = match;
            claim_next = candidate && !chain_in.claimed;
        end
        if (upd.en)
        begin
            if (upd.hit)
            begin
                if (match_reg)
                begin
                    rank_next = '0;
                    if (upd.op == OP_INSERT)
                    begin
                        value_next = upd.value;
                    end
                end
                else if (valid_reg && (rank_reg < upd.hit_rank))
                begin
                    rank_next = rank_reg + 1'b1;
                end
            end
            else if (upd.op == OP_INSERT)
            begin
                if (claim_reg)
                begin
                    key_next   = upd.key;
                    value_next = upd.value;
                    valid_next = 1'b1;
                    rank_next  = '0;
                end
                else if (valid_reg)
                begin
                    rank_next = rank_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
            match_reg <= 1'b0;
            claim_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            match_reg <= match_next;
            claim_reg <= claim_next;
        end
    end

endmodule

`default_nettype wire

[rtl/lkvc_checker.sv]
// Port-level checks of the LRU key-value cache, bound to the top level.
`default_nettype none

module lkvc_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [63:0]  m_tdata,
    input wire logic [0:0]   m_tuser
);

    // A result that is still waiting must not disappear.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A miss always carries a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == 64'd0)
        else $error("miss with nonzero read value");

    // Requests are handled one at a time, so two transfers never come in a row.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request transfers in consecutive cycles");

    // A result that appears on an empty output stems from an earlier accepted request.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 3))
        else $error("result without a matching request");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (.*);

`default_nettype wire
